// ----- src/tcs_pkg.sv -----
`timescale 1ns / 1ps
// tcs_pkg: shared types, codes and helpers for the TCP connection sequencer.
// Used by tcs_front, tcs_back and tcp_connection_sequencer_core. No dependencies.
package tcs_pkg;

  // Input opcodes
  localparam logic [1:0] OP_OPEN    = 2'd0;
  localparam logic [1:0] OP_SEND    = 2'd1;
  localparam logic [1:0] OP_SEGMENT = 2'd2;

  // TCP flag bits
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  // Reported connection state codes
  localparam logic [1:0] CS_NONE        = 2'd0;
  localparam logic [1:0] CS_OPENED      = 2'd1;
  localparam logic [1:0] CS_HANDSHAKE   = 2'd2;
  localparam logic [1:0] CS_ESTABLISHED = 2'd3;

  // Register map (byte address of initial_sequence)
  localparam int         ADDR_W                = 2;
  localparam logic [1:0] ADDR_INITIAL_SEQUENCE = 2'd0;

  // Connection state machine, one-hot
  typedef enum logic [3:0] {
    ST_NONE        = 4'b0001,
    ST_OPENED      = 4'b0010,
    ST_HANDSHAKE   = 4'b0100,
    ST_ESTABLISHED = 4'b1000
  } conn_state_t;

  // Class of a word as sorted by the front end
  typedef enum logic [2:0] {
    KIND_OPEN      = 3'd0,
    KIND_SEND      = 3'd1,
    KIND_SEGMENT   = 3'd2,
    KIND_MALFORMED = 3'd3,
    KIND_IGNORE    = 3'd4
  } kind_t;

  // Classified word passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        fin;
    logic        rst;
    logic        syn_ack;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [15:0] rx_window;
    logic [15:0] data_length;
    logic [15:0] send_length;
  } front_word_t;

  // Result word
  typedef struct packed {
    logic        emit_segment;
    logic [7:0]  tx_flags;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [15:0] tx_length;
    logic        deliver_data;
    logic [15:0] deliver_length;
    logic        send_accepted;
    logic        malformed;
    logic [1:0]  conn_state;
  } result_word_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic in_empty;
    logic out_full;
  } back_status_t;

  function automatic logic [1:0] encode_state(input conn_state_t st);
    logic [1:0] code;
    case (st)
      ST_NONE:        code = CS_NONE;
      ST_OPENED:      code = CS_OPENED;
      ST_HANDSHAKE:   code = CS_HANDSHAKE;
      ST_ESTABLISHED: code = CS_ESTABLISHED;
      default:        code = CS_NONE;
    endcase
    return code;
  endfunction

endpackage

// ----- src/tcs_fifo.sv -----
`timescale 1ns / 1ps
// tcs_fifo: small register-based word queue with push/full and pop/empty sides.
// Generic; no package dependencies.
module tcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/tcs_front.sv -----
`timescale 1ns / 1ps
// tcs_front: sorts each incoming word by opcode, checks header length, and
// precomputes flag tests and data length. Depends on tcs_pkg.
module tcs_front (
  input  logic                 [1:0]  opcode,
  input  logic                 [7:0]  rx_flags,
  input  logic                 [31:0] rx_seq,
  input  logic                 [31:0] rx_ack,
  input  logic                 [15:0] rx_window,
  input  logic                 [3:0]  rx_header_words,
  input  logic                 [15:0] rx_length,
  input  logic                 [15:0] send_length,
  output tcs_pkg::front_word_t        word
);

  logic [15:0] header_bytes;
  logic        too_short;

  assign header_bytes = {10'd0, rx_header_words, 2'b00};
  assign too_short    = header_bytes > rx_length;

  // classification
  always_comb begin
    word.rx_seq      = rx_seq;
    word.rx_ack      = rx_ack;
    word.rx_window   = rx_window;
    word.send_length = send_length;
    word.data_length = rx_length - header_bytes;
    word.fin         = |(rx_flags & tcs_pkg::FLAG_FIN);
    word.rst         = |(rx_flags & tcs_pkg::FLAG_RST);
    word.syn_ack     = (|(rx_flags & tcs_pkg::FLAG_SYN)) && (|(rx_flags & tcs_pkg::FLAG_ACK));
    case (opcode)
      tcs_pkg::OP_OPEN:    word.kind = tcs_pkg::KIND_OPEN;
      tcs_pkg::OP_SEND:    word.kind = tcs_pkg::KIND_SEND;
      tcs_pkg::OP_SEGMENT: word.kind = too_short ? tcs_pkg::KIND_MALFORMED
                                                 : tcs_pkg::KIND_SEGMENT;
      default:             word.kind = tcs_pkg::KIND_IGNORE;
    endcase
  end

endmodule

// ----- src/tcs_back.sv -----
`timescale 1ns / 1ps
// tcs_back: connection FSM and sequence counters; runs one classified
// word per cycle into a result word unless stalled. Depends on tcs_pkg.
module tcs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                   [31:0] initial_sequence,
  input  tcs_pkg::back_status_t         status,
  input  tcs_pkg::front_word_t          word,
  output logic                          take,
  output tcs_pkg::result_word_t         result
);

  tcs_pkg::conn_state_t state;
  tcs_pkg::conn_state_t state_next;
  logic [31:0] send_next;
  logic [31:0] send_next_next;
  logic [31:0] receive_next;
  logic [31:0] receive_next_next;
  logic [31:0] rst_offset;
  logic        rst_in_window;
  logic [31:0] rcv_plus_one;
  logic [31:0] rcv_plus_data;
  logic [31:0] seq_plus_one;

  assign take          = !status.in_empty && !status.out_full;
  assign rst_offset    = word.rx_seq - receive_next;
  assign rst_in_window = rst_offset < {16'd0, word.rx_window};
  assign rcv_plus_one  = receive_next + 32'd1;
  assign rcv_plus_data = receive_next + {16'd0, word.data_length};
  assign seq_plus_one  = word.rx_seq + 32'd1;

  // per-word decision
  always_comb begin
    state_next        = state;
    send_next_next    = send_next;
    receive_next_next = receive_next;
    result            = '0;
    case (word.kind)
      tcs_pkg::KIND_OPEN: begin
        state_next        = tcs_pkg::ST_OPENED;
        send_next_next    = initial_sequence;
        receive_next_next = '0;
      end
      tcs_pkg::KIND_SEND: begin
        if (state == tcs_pkg::ST_OPENED) begin
          result.emit_segment  = 1'b1;
          result.tx_flags      = tcs_pkg::FLAG_SYN;
          result.tx_seq        = send_next;
          result.send_accepted = 1'b1;
          send_next_next       = send_next + 32'd1;
          state_next           = tcs_pkg::ST_HANDSHAKE;
        end else if (state == tcs_pkg::ST_ESTABLISHED) begin
          result.emit_segment  = 1'b1;
          result.tx_flags      = tcs_pkg::FLAG_ACK | tcs_pkg::FLAG_PSH;
          result.tx_seq        = send_next;
          result.tx_ack        = receive_next;
          result.tx_length     = word.send_length;
          result.send_accepted = 1'b1;
          send_next_next       = send_next + {16'd0, word.send_length};
        end
      end
      tcs_pkg::KIND_MALFORMED: begin
        result.malformed = 1'b1;
      end
      tcs_pkg::KIND_SEGMENT: begin
        if (state == tcs_pkg::ST_NONE) begin
          // no connection: dropped
        end else if (word.fin) begin
          receive_next_next   = rcv_plus_one;
          result.emit_segment = 1'b1;
          result.tx_flags     = tcs_pkg::FLAG_ACK;
          result.tx_seq       = send_next;
          result.tx_ack       = rcv_plus_one;
          state_next          = tcs_pkg::ST_NONE;
        end else if (word.rst) begin
          if (rst_in_window) begin
            state_next = tcs_pkg::ST_NONE;
          end
        end else if (state == tcs_pkg::ST_HANDSHAKE) begin
          if (word.syn_ack && (word.rx_ack == send_next)) begin
            receive_next_next   = seq_plus_one;
            result.emit_segment = 1'b1;
            result.tx_flags     = tcs_pkg::FLAG_ACK;
            result.tx_seq       = send_next;
            result.tx_ack       = seq_plus_one;
            state_next          = tcs_pkg::ST_ESTABLISHED;
          end
        end else if (state == tcs_pkg::ST_ESTABLISHED) begin
          if (word.data_length != '0) begin
            result.emit_segment = 1'b1;
            result.tx_flags     = tcs_pkg::FLAG_ACK;
            result.tx_seq       = send_next;
            if (word.rx_seq == receive_next) begin
              receive_next_next     = rcv_plus_data;
              result.deliver_data   = 1'b1;
              result.deliver_length = word.data_length;
              result.tx_ack         = rcv_plus_data;
            end else begin
              // out of order: duplicate ACK
              result.tx_ack = receive_next;
            end
          end
        end
      end
      default: begin
      end
    endcase
    result.conn_state = tcs_pkg::encode_state(state_next);
  end

  // connection registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tcs_pkg::ST_NONE;
      send_next    <= '0;
      receive_next <= '0;
    end else if (take) begin
      state        <= state_next;
      send_next    <= send_next_next;
      receive_next <= receive_next_next;
    end
  end

endmodule

// ----- src/tcp_connection_sequencer_core.sv -----
`timescale 1ns / 1ps
// TCP connection sequencer core: client-side state machine of one TCP
// connection. Takes one word per clock unless full (open, send request or received
// segment header) and returns exactly one result word for each, in order.
// A word is classified on its way into a short queue, executed against the
// connection state when the back end takes it, and its result word is queued
// for the result ports. The state update (32-bit adds and a window compare)
// is combinational, so the sustained rate is one word per cycle while the
// result side keeps popping.
// Either side may stall independently; the queues absorb the difference.
// initial_sequence sits at byte address 0 of the APB port and is loaded on open.
// Depends on tcs_pkg, tcs_fifo, tcs_front and tcs_back.
module tcp_connection_sequencer_core #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input words
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 opcode,
  input  logic [7:0]                 rx_flags,
  input  logic [31:0]                rx_seq,
  input  logic [31:0]                rx_ack,
  input  logic [15:0]                rx_window,
  input  logic [3:0]                 rx_header_words,
  input  logic [15:0]                rx_length,
  input  logic [15:0]                send_length,
  // result words
  output logic                       empty,
  input  logic                       pop,
  output logic                       emit_segment,
  output logic [7:0]                 tx_flags,
  output logic [31:0]                tx_seq,
  output logic [31:0]                tx_ack,
  output logic [15:0]                tx_length,
  output logic                       deliver_data,
  output logic [15:0]                deliver_length,
  output logic                       send_accepted,
  output logic                       malformed,
  output logic [1:0]                 conn_state
);

  localparam int FW_W = $bits(tcs_pkg::front_word_t);
  localparam int RW_W = $bits(tcs_pkg::result_word_t);

  logic [31:0]           initial_sequence;
  tcs_pkg::front_word_t  front_word;
  tcs_pkg::front_word_t  mid_word;
  tcs_pkg::result_word_t back_result;
  tcs_pkg::result_word_t out_word;
  tcs_pkg::back_status_t back_status;
  logic [FW_W-1:0]       mid_rdata;
  logic [RW_W-1:0]       out_rdata;
  logic                  mid_empty;
  logic                  out_full;
  logic                  back_take;
  logic                  reg_hit;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr == tcs_pkg::ADDR_INITIAL_SEQUENCE);
  assign prdata  = reg_hit ? initial_sequence : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_sequence <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      initial_sequence <= pwdata;
    end
  end

  // front end: classify
  tcs_front u_front (
    .opcode          (opcode),
    .rx_flags        (rx_flags),
    .rx_seq          (rx_seq),
    .rx_ack          (rx_ack),
    .rx_window       (rx_window),
    .rx_header_words (rx_header_words),
    .rx_length       (rx_length),
    .send_length     (send_length),
    .word            (front_word)
  );

  // queue between front and back
  tcs_fifo #(
    .WIDTH (FW_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_word),
    .full  (full),
    .pop   (back_take),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_word             = tcs_pkg::front_word_t'(mid_rdata);
  assign back_status.in_empty = mid_empty;
  assign back_status.out_full = out_full;

  // back end: execute
  tcs_back u_back (
    .clk              (clk),
    .rst              (rst),
    .initial_sequence (initial_sequence),
    .status           (back_status),
    .word             (mid_word),
    .take             (back_take),
    .result           (back_result)
  );

  // result queue
  tcs_fifo #(
    .WIDTH (RW_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (back_take),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_word       = tcs_pkg::result_word_t'(out_rdata);
  assign emit_segment   = out_word.emit_segment;
  assign tx_flags       = out_word.tx_flags;
  assign tx_seq         = out_word.tx_seq;
  assign tx_ack         = out_word.tx_ack;
  assign tx_length      = out_word.tx_length;
  assign deliver_data   = out_word.deliver_data;
  assign deliver_length = out_word.deliver_length;
  assign send_accepted  = out_word.send_accepted;
  assign malformed      = out_word.malformed;
  assign conn_state     = out_word.conn_state;

endmodule

// ----- test/tcp_connection_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tcp_connection_sequencer_core: drives open, send and segment
// words with bursty traffic, predicts every result word and checks them in order.
// Depends on tcs_pkg and the sequencer RTL.
module tcp_connection_sequencer_core_tb;
  import tcs_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         EXT_NONE    = 0;
  localparam int         EXT_HIGH    = 1;
  localparam int         EXT_LOW     = 2;
  localparam int         HOLD_CYCLES = 80;
  localparam int         PHASE_WORDS = 125;
  localparam int         DRAIN_LIMIT = 20000;

  // One input word as seen on the ports
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [3:0]  hdr_words;
    logic [15:0] rlen;
    logic [15:0] slen;
  } seg_word_t;

  // Kinds of stimulus word
  typedef enum int {
    W_OPEN, W_SEND, W_UNUSED, W_NOISE, W_MALFORMED, W_SYNACK, W_SYNACK_BAD,
    W_DATA, W_DATA_OOO, W_DATA_EMPTY, W_FIN, W_RST_IN, W_RST_OUT
  } word_kind_t;

  // Connection tracker: mirrors the sequencer state and queues the expected result words
  class tcp_scoreboard;
    logic [31:0]  isn;
    logic [1:0]   conn;
    logic [31:0]  snd_nxt;
    logic [31:0]  snd_una;
    logic [31:0]  rcv_nxt;
    result_word_t pending_results[$];
    int           errors;
    int           results_seen;

    function new();
      isn = '0;
      conn = CS_NONE;
      snd_nxt = '0;
      snd_una = '0;
      rcv_nxt = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void note_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void set_isn(logic [31:0] v);
      isn = v;
    endfunction

    // Pure ACK at the current send position
    function result_word_t ack_word();
      result_word_t r;
      r = '0;
      r.emit_segment = 1'b1;
      r.tx_flags     = FLAG_ACK;
      r.tx_seq       = snd_nxt;
      r.tx_ack       = rcv_nxt;
      return r;
    endfunction

    // Apply one word to the connection and return the result it yields
    function result_word_t segment_result(seg_word_t w);
      result_word_t r;
      logic [16:0]  hdr_bytes;
      logic [15:0]  dlen;
      r = '0;
      hdr_bytes = {11'd0, w.hdr_words, 2'b00};
      case (w.opcode)
        OP_OPEN: begin
          conn = CS_OPENED;
          snd_nxt = isn;
          snd_una = isn;
          rcv_nxt = '0;
        end
        OP_SEND: begin
          if (conn == CS_OPENED) begin
            r.emit_segment  = 1'b1;
            r.tx_flags      = FLAG_SYN;
            r.tx_seq        = snd_nxt;
            r.send_accepted = 1'b1;
            snd_nxt = snd_nxt + 32'd1;
            conn = CS_HANDSHAKE;
          end else if (conn == CS_ESTABLISHED) begin
            r.emit_segment  = 1'b1;
            r.tx_flags      = FLAG_ACK | FLAG_PSH;
            r.tx_seq        = snd_nxt;
            r.tx_ack        = rcv_nxt;
            r.tx_length     = w.slen;
            r.send_accepted = 1'b1;
            snd_nxt = snd_nxt + {16'd0, w.slen};
          end
        end
        OP_SEGMENT: begin
          if (hdr_bytes > {1'b0, w.rlen}) begin
            r.malformed = 1'b1;
          end else if (conn == CS_NONE) begin
            // no connection: dropped
          end else if ((w.flags & FLAG_FIN) != '0) begin
            rcv_nxt = rcv_nxt + 32'd1;
            r = ack_word();
            conn = CS_NONE;
          end else if ((w.flags & FLAG_RST) != '0) begin
            // reset only counts inside the wrapping receive window
            if ((w.seq - rcv_nxt) < {16'd0, w.win}) conn = CS_NONE;
          end else if (conn == CS_HANDSHAKE) begin
            if ((w.flags & FLAG_SYN) != '0 && (w.flags & FLAG_ACK) != '0 &&
                w.ack == snd_nxt) begin
              rcv_nxt = w.seq + 32'd1;
              snd_una = w.ack;
              r = ack_word();
              conn = CS_ESTABLISHED;
            end
          end else if (conn == CS_ESTABLISHED) begin
            dlen = w.rlen - hdr_bytes[15:0];
            if (dlen != '0) begin
              if (w.seq != rcv_nxt) begin
                r = ack_word();
              end else begin
                rcv_nxt = rcv_nxt + {16'd0, dlen};
                r = ack_word();
                r.deliver_data   = 1'b1;
                r.deliver_length = dlen;
              end
            end
          end
        end
        default: ;
      endcase
      r.conn_state = conn;
      return r;
    endfunction

    function void note_word(seg_word_t w);
      pending_results.push_back(segment_result(w));
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a)
        note_mismatch($sformatf("word %0d %s: expected %h, got %h", results_seen, name, e, a));
    endfunction

    function void check_word(result_word_t got);
      result_word_t exp;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("word %0d arrived with nothing expected", results_seen));
      end else begin
        exp = pending_results.pop_front();
        compare_field("emit_segment", 32'(exp.emit_segment), 32'(got.emit_segment));
        compare_field("tx_flags", 32'(exp.tx_flags), 32'(got.tx_flags));
        compare_field("tx_seq", exp.tx_seq, got.tx_seq);
        compare_field("tx_ack", exp.tx_ack, got.tx_ack);
        compare_field("tx_length", 32'(exp.tx_length), 32'(got.tx_length));
        compare_field("deliver_data", 32'(exp.deliver_data), 32'(got.deliver_data));
        compare_field("deliver_length", 32'(exp.deliver_length), 32'(got.deliver_length));
        compare_field("send_accepted", 32'(exp.send_accepted), 32'(got.send_accepted));
        compare_field("malformed", 32'(exp.malformed), 32'(got.malformed));
        compare_field("conn_state", 32'(exp.conn_state), 32'(got.conn_state));
      end
      results_seen++;
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              push;
  logic              full;
  logic [1:0]        opcode;
  logic [7:0]        rx_flags;
  logic [31:0]       rx_seq;
  logic [31:0]       rx_ack;
  logic [15:0]       rx_window;
  logic [3:0]        rx_header_words;
  logic [15:0]       rx_length;
  logic [15:0]       send_length;
  logic              empty;
  logic              pop;
  logic              emit_segment;
  logic [7:0]        tx_flags;
  logic [31:0]       tx_seq;
  logic [31:0]       tx_ack;
  logic [15:0]       tx_length;
  logic              deliver_data;
  logic [15:0]       deliver_length;
  logic              send_accepted;
  logic              malformed;
  logic [1:0]        conn_state;

  bit                hold_req;
  tcp_scoreboard     sb = new();

  tcp_connection_sequencer_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .push(push), .full(full), .opcode(opcode), .rx_flags(rx_flags), .rx_seq(rx_seq),
    .rx_ack(rx_ack), .rx_window(rx_window), .rx_header_words(rx_header_words),
    .rx_length(rx_length), .send_length(send_length),
    .empty(empty), .pop(pop), .emit_segment(emit_segment), .tx_flags(tx_flags),
    .tx_seq(tx_seq), .tx_ack(tx_ack), .tx_length(tx_length), .deliver_data(deliver_data),
    .deliver_length(deliver_length), .send_accepted(send_accepted),
    .malformed(malformed), .conn_state(conn_state)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Random values biased toward the ends of the range
  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 7))
      0: return 16'h0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] nonzero32();
    logic [31:0] v;
    v = rnd32();
    if (v == '0) v = 32'd1;
    return v;
  endfunction

  // Build a word of the given kind against the current connection state
  function automatic seg_word_t make_word(word_kind_t k, int ext);
    seg_word_t w;
    int        hdr_b;
    w.opcode    = OP_SEGMENT;
    w.flags     = 8'($urandom_range(0, 255));
    w.seq       = rnd32();
    w.ack       = rnd32();
    w.win       = rnd16();
    w.hdr_words = (ext == EXT_HIGH) ? 4'hF : (ext == EXT_LOW) ? 4'h0 :
                  4'($urandom_range(0, 15));
    w.slen      = rnd16();
    hdr_b       = int'(w.hdr_words) * 4;
    w.rlen      = (ext == EXT_HIGH) ? 16'hFFFF : 16'(hdr_b + $urandom_range(0, 65535 - hdr_b));
    case (k)
      W_OPEN: w.opcode = OP_OPEN;
      W_SEND: begin
        w.opcode = OP_SEND;
        if (ext == EXT_HIGH) w.slen = 16'hFFFF;
        else if (ext == EXT_LOW) w.slen = 16'h0;
      end
      W_UNUSED: w.opcode = OP_UNUSED;
      W_NOISE: begin
        w.opcode    = 2'($urandom_range(0, 3));
        w.hdr_words = 4'($urandom_range(0, 15));
        w.rlen      = rnd16();
      end
      W_MALFORMED: begin
        w.hdr_words = (ext == EXT_HIGH) ? 4'hF : (ext == EXT_LOW) ? 4'h1 :
                      4'($urandom_range(1, 15));
        hdr_b  = int'(w.hdr_words) * 4;
        w.rlen = (ext == EXT_NONE) ? 16'($urandom_range(0, hdr_b - 1)) : 16'(hdr_b - 1);
      end
      W_SYNACK: begin
        w.flags = (w.flags & ~(FLAG_FIN | FLAG_RST)) | FLAG_SYN | FLAG_ACK;
        w.ack   = sb.snd_nxt;
      end
      W_SYNACK_BAD: begin
        w.flags = w.flags & ~(FLAG_FIN | FLAG_RST);
        w.ack   = sb.snd_nxt;
        case ($urandom_range(0, 2))
          0: begin
            w.flags = w.flags | FLAG_SYN | FLAG_ACK;
            w.ack   = sb.snd_nxt + nonzero32();
          end
          1: w.flags = (w.flags | FLAG_ACK) & ~FLAG_SYN;
          default: w.flags = (w.flags | FLAG_SYN) & ~FLAG_ACK;
        endcase
      end
      W_DATA, W_DATA_OOO: begin
        w.flags = w.flags & ~(FLAG_FIN | FLAG_RST);
        if (ext == EXT_LOW) w.rlen = 16'd1;
        else if (ext == EXT_NONE) w.rlen = 16'(hdr_b + $urandom_range(1, 65535 - hdr_b));
        w.seq = (k == W_DATA) ? sb.rcv_nxt : sb.rcv_nxt + nonzero32();
      end
      W_DATA_EMPTY: begin
        w.flags = w.flags & ~(FLAG_FIN | FLAG_RST);
        w.rlen  = 16'(hdr_b);
        if ($urandom_range(0, 1) == 0) w.seq = sb.rcv_nxt;
      end
      W_FIN: w.flags = w.flags | FLAG_FIN;
      W_RST_IN: begin
        w.flags = (w.flags & ~FLAG_FIN) | FLAG_RST;
        if (ext == EXT_HIGH) begin
          w.win = 16'hFFFF;
          w.seq = sb.rcv_nxt + 32'hFFFE;
        end else begin
          w.win = (ext == EXT_LOW) ? 16'd1 : 16'($urandom_range(1, 65535));
          w.seq = sb.rcv_nxt + $urandom_range(0, int'(w.win) - 1);
        end
      end
      W_RST_OUT: begin
        w.flags = (w.flags & ~FLAG_FIN) | FLAG_RST;
        if (ext == EXT_HIGH) begin
          w.win = 16'h0;
          w.seq = sb.rcv_nxt;
        end else begin
          w.seq = sb.rcv_nxt + {16'd0, w.win} + ($urandom & 32'h7FFF_FFFF);
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // Mostly well-formed traffic for the state the connection is in
  function automatic word_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    case (sb.conn)
      CS_NONE: begin
        if (r < 55) return W_OPEN;
        if (r < 65) return W_SEND;
        if (r < 75) return W_MALFORMED;
        if (r < 85) return W_DATA;
        if (r < 95) return W_NOISE;
        return W_UNUSED;
      end
      CS_OPENED: begin
        if (r < 65) return W_SEND;
        if (r < 72) return W_OPEN;
        if (r < 78) return W_DATA;
        if (r < 84) return W_MALFORMED;
        if (r < 88) return W_FIN;
        if (r < 92) return W_RST_IN;
        return W_NOISE;
      end
      CS_HANDSHAKE: begin
        if (r < 55) return W_SYNACK;
        if (r < 70) return W_SYNACK_BAD;
        if (r < 76) return W_SEND;
        if (r < 80) return W_FIN;
        if (r < 84) return W_RST_IN;
        if (r < 88) return W_RST_OUT;
        if (r < 93) return W_MALFORMED;
        return W_NOISE;
      end
      default: begin
        if (r < 28) return W_DATA;
        if (r < 50) return W_SEND;
        if (r < 60) return W_DATA_OOO;
        if (r < 65) return W_DATA_EMPTY;
        if (r < 69) return W_FIN;
        if (r < 72) return W_RST_IN;
        if (r < 78) return W_RST_OUT;
        if (r < 82) return W_MALFORMED;
        if (r < 86) return W_SYNACK;
        if (r < 93) return W_NOISE;
        if (r < 97) return W_OPEN;
        return W_UNUSED;
      end
    endcase
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic offer(input word_kind_t k, input int ext);
    seg_word_t w;
    @(negedge clk);
    w = make_word(k, ext);
    opcode          <= w.opcode;
    rx_flags        <= w.flags;
    rx_seq          <= w.seq;
    rx_ack          <= w.ack;
    rx_window       <= w.win;
    rx_header_words <= w.hdr_words;
    rx_length       <= w.rlen;
    send_length     <= w.slen;
    push            <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  task automatic idle(input int cycles);
    @(negedge clk);
    push <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop offering and wait for every expected word to come out
  task automatic drain();
    int n;
    idle(1);
    n = 0;
    while (sb.pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // APB write of initial_sequence, then a read back
  task automatic set_initial_sequence(input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_INITIAL_SEQUENCE;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v)
      sb.note_mismatch($sformatf("initial_sequence read: expected %h, got %h", v, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random bursts, most of them followed by a gap
  task automatic run_phase(input int n_words);
    int         count;
    int         burst;
    word_kind_t k;
    count = 0;
    while (count < n_words) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && count < n_words; i++) begin
        k = pick_kind();
        offer(k, EXT_NONE);
        count++;
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
    end
  endtask

  // Sample both handshakes and the register port at the rising edge
  always @(posedge clk) begin
    seg_word_t    w;
    result_word_t r;
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr == ADDR_INITIAL_SEQUENCE)
        sb.set_isn(pwdata);
      if (push && !full) begin
        w = '{opcode, rx_flags, rx_seq, rx_ack, rx_window, rx_header_words,
              rx_length, send_length};
        sb.note_word(w);
      end
      if (pop && !empty) begin
        r = '{emit_segment, tx_flags, tx_seq, tx_ack, tx_length, deliver_data,
              deliver_length, send_accepted, malformed, conn_state};
        sb.check_word(r);
      end
    end
  end

  // Result side: stall patterns that change now and then, plus one long hold-off
  initial begin
    int style;
    int style_left;
    int tick;
    int hold_left;
    pop = 1'b0;
    style = 0;
    style_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        hold_req = 1'b0;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        tick++;
        case (style)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ((tick % 8) < 5);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] isn_list[5];
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    opcode = OP_OPEN;
    rx_flags = '0;
    rx_seq = '0;
    rx_ack = '0;
    rx_window = '0;
    rx_header_words = '0;
    rx_length = '0;
    send_length = '0;
    hold_req = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: send sequence wraps right after the SYN
    set_initial_sequence(32'hFFFF_FFFF);
    offer(W_UNUSED, EXT_NONE);
    offer(W_MALFORMED, EXT_HIGH);
    offer(W_DATA, EXT_NONE);        // segment with no connection
    offer(W_SEND, EXT_NONE);        // send with no connection
    offer(W_OPEN, EXT_NONE);
    offer(W_DATA, EXT_HIGH);        // dropped while only opened
    offer(W_SEND, EXT_NONE);        // SYN
    offer(W_SEND, EXT_HIGH);        // rejected while the handshake is pending
    offer(W_SYNACK_BAD, EXT_NONE);
    offer(W_RST_OUT, EXT_HIGH);     // zero window
    offer(W_SYNACK, EXT_NONE);
    offer(W_DATA, EXT_HIGH);
    offer(W_DATA, EXT_LOW);
    offer(W_DATA_OOO, EXT_NONE);
    offer(W_DATA_EMPTY, EXT_NONE);
    offer(W_MALFORMED, EXT_LOW);
    offer(W_SEND, EXT_HIGH);
    offer(W_SEND, EXT_LOW);
    offer(W_RST_OUT, EXT_NONE);
    offer(W_RST_IN, EXT_HIGH);
    offer(W_OPEN, EXT_NONE);
    offer(W_SEND, EXT_NONE);
    offer(W_FIN, EXT_NONE);         // FIN before the handshake finishes
    offer(W_OPEN, EXT_NONE);
    offer(W_SEND, EXT_NONE);
    offer(W_SYNACK, EXT_NONE);
    offer(W_RST_IN, EXT_LOW);
    drain();

    // Random phases over several initial sequence numbers
    isn_list[0] = 32'h0;
    isn_list[1] = $urandom;
    isn_list[2] = 32'hFFFF_FFF0;
    isn_list[3] = 32'h8000_0000;
    isn_list[4] = $urandom;
    for (int p = 0; p < 5; p++) begin
      set_initial_sequence(isn_list[p]);
      if (p == 2) hold_req = 1'b1;
      run_phase(PHASE_WORDS);
      drain();
    end

    if (sb.pending_results.size() != 0)
      sb.note_mismatch($sformatf("%0d result words never arrived",
                                 sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
